>>> rtl/afgt_pkg.sv
// shared types and constants of the audio frame grid tick block
`timescale 1ns / 1ps
package afgt_pkg;

    localparam logic [2:0] CFG_ORIGIN_VALUE      = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_TIMESCALE  = 3'd1;
    localparam logic [2:0] CFG_SAMPLE_RATE       = 3'd2;
    localparam logic [2:0] CFG_SAMPLES_PER_FRAME = 3'd3;
    localparam logic [2:0] CFG_TICK_SCALE_NS     = 3'd4;

    localparam logic [15:0] RATE_A        = 16'd44100;
    localparam logic [15:0] RATE_B        = 16'd48000;
    localparam logic [31:0] NS_PER_SECOND = 32'd1000000000;

    localparam logic [6:0] MUL_STEPS = 7'd31;
    localparam logic [6:0] DIV_STEPS = 7'd127;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_MUL_STEP,
        OP_SET_B,
        OP_SET_A,
        OP_SET_D,
        OP_CMP,
        OP_COMB,
        OP_DIV_STEP,
        OP_GCD_INIT,
        OP_GCD_STEP,
        OP_SET_NR,
        OP_SET_DR,
        OP_CHECK,
        OP_SET_NS,
        OP_SET_Q,
        OP_ROUND,
        OP_FINISH,
        OP_FAIL
    } dp_op_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_P1,
        ST_SET_B,
        ST_MUL_B,
        ST_SET_A,
        ST_MUL_A,
        ST_SET_D,
        ST_MUL_D,
        ST_CMP,
        ST_COMB,
        ST_DIV_R,
        ST_GCD_INIT,
        ST_GCD,
        ST_SET_NR,
        ST_DIV_NR,
        ST_SET_DR,
        ST_DIV_DR,
        ST_CHECK,
        ST_MUL_DEN,
        ST_SET_NS,
        ST_MUL_NS,
        ST_SET_Q,
        ST_DIV_Q,
        ST_ROUND,
        ST_FINISH,
        ST_FAIL
    } state_t;

    typedef struct packed {
        dp_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic cfg_bad;
        logic gcd_done;
        logic range_fail;
        logic out_busy;
    } dp_status_t;

endpackage

>>> rtl/afgt_ctrl.sv
// sequencer for the grid tick datapath
`timescale 1ns / 1ps
module afgt_ctrl
    import afgt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_beat,
    output logic       in_ready,
    output ctrl_cmd_t  cmd,
    input  dp_status_t status
);

    state_t     state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd.op     = OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_beat)
                begin
                    cmd.op     = OP_CAPTURE;
                    cnt_next   = MUL_STEPS;
                    state_next = status.cfg_bad ? ST_FAIL : ST_MUL_P1;
                end
            end
            ST_MUL_P1, ST_MUL_B, ST_MUL_A, ST_MUL_D, ST_MUL_DEN, ST_MUL_NS:
            begin
                cmd.op   = OP_MUL_STEP;
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == '0)
                begin
                    unique case (state_reg)
                        ST_MUL_P1:  state_next = ST_SET_B;
                        ST_MUL_B:   state_next = ST_SET_A;
                        ST_MUL_A:   state_next = ST_SET_D;
                        ST_MUL_D:   state_next = ST_CMP;
                        ST_MUL_DEN: state_next = ST_SET_NS;
                        default:    state_next = ST_SET_Q;
                    endcase
                end
            end
            ST_DIV_R, ST_DIV_NR, ST_DIV_DR, ST_DIV_Q:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == '0)
                begin
                    unique case (state_reg)
                        ST_DIV_R:  state_next = ST_GCD_INIT;
                        ST_DIV_NR: state_next = ST_SET_DR;
                        ST_DIV_DR: state_next = ST_CHECK;
                        default:   state_next = ST_ROUND;
                    endcase
                end
            end
            ST_SET_B:
            begin
                cmd.op = OP_SET_B; cnt_next = MUL_STEPS; state_next = ST_MUL_B;
            end
            ST_SET_A:
            begin
                cmd.op = OP_SET_A; cnt_next = MUL_STEPS; state_next = ST_MUL_A;
            end
            ST_SET_D:
            begin
                cmd.op = OP_SET_D; cnt_next = MUL_STEPS; state_next = ST_MUL_D;
            end
            ST_CMP:
            begin
                cmd.op = OP_CMP; state_next = ST_COMB;
            end
            ST_COMB:
            begin
                cmd.op = OP_COMB; cnt_next = DIV_STEPS; state_next = ST_DIV_R;
            end
            ST_GCD_INIT:
            begin
                cmd.op = OP_GCD_INIT; state_next = ST_GCD;
            end
            ST_GCD:
            begin
                if (status.gcd_done)
                    state_next = ST_SET_NR;
                else
                    cmd.op = OP_GCD_STEP;
            end
            ST_SET_NR:
            begin
                cmd.op = OP_SET_NR; cnt_next = DIV_STEPS; state_next = ST_DIV_NR;
            end
            ST_SET_DR:
            begin
                cmd.op = OP_SET_DR; cnt_next = DIV_STEPS; state_next = ST_DIV_DR;
            end
            ST_CHECK:
            begin
                cmd.op     = OP_CHECK;
                cnt_next   = MUL_STEPS;
                state_next = status.range_fail ? ST_FAIL : ST_MUL_DEN;
            end
            ST_SET_NS:
            begin
                cmd.op = OP_SET_NS; cnt_next = MUL_STEPS; state_next = ST_MUL_NS;
            end
            ST_SET_Q:
            begin
                cmd.op = OP_SET_Q; cnt_next = DIV_STEPS; state_next = ST_DIV_Q;
            end
            ST_ROUND:
            begin
                cmd.op = OP_ROUND; state_next = ST_FINISH;
            end
            ST_FINISH, ST_FAIL:
            begin
                if (!status.out_busy)
                begin
                    cmd.op     = (state_reg == ST_FINISH) ? OP_FINISH : OP_FAIL;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

>>> rtl/afgt_dp.sv
// shift-add multiplier, restoring divider, binary gcd and result register
`timescale 1ns / 1ps
module afgt_dp
    import afgt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ctrl_cmd_t    cmd,
    output dp_status_t   status,
    input  logic [63:0]  origin_value,
    input  logic [30:0]  origin_timescale,
    input  logic [15:0]  sample_rate,
    input  logic [15:0]  samples_per_frame,
    input  logic [31:0]  tick_scale_ns,
    input  logic [63:0]  frame_ordinal,
    input  logic [63:0]  observed_tick,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [63:0]  grid_tick,
    output logic         ok,
    output logic         tick_matches
);

    logic [63:0]  obs_reg, omag_reg;
    logic         oneg_reg, neg_reg, ge_reg;
    logic [127:0] acc_reg, mcand_reg, a_reg, b_reg, mag_reg, nr_reg;
    logic [31:0]  mplier_reg;
    logic [127:0] dvd_reg, quo_reg;
    logic [63:0]  dvs_reg, rem_reg, d_reg, g_reg, den_reg;
    logic [63:0]  u_reg, v_reg;
    logic [5:0]   k_reg;
    logic         out_valid_reg;
    logic [63:0]  tick_reg;
    logic         ok_reg, match_reg;

    logic [64:0]  div_shift;
    logic         div_take;
    logic [63:0]  half;
    logic         round_up;
    logic [63:0]  dr_val;
    logic [63:0]  q_tick;

    assign div_shift = {rem_reg, dvd_reg[127]};
    assign div_take  = div_shift >= {1'b0, dvs_reg};
    assign half      = {1'b0, den_reg[63:1]};
    assign round_up  = (rem_reg > half) ||
                       (!den_reg[0] && rem_reg == half && quo_reg[0]);
    assign dr_val    = quo_reg[63:0];
    assign q_tick    = neg_reg ? (~quo_reg[63:0] + 64'd1) : quo_reg[63:0];

    assign status.cfg_bad    = (origin_timescale == '0) ||
                               (sample_rate != RATE_A && sample_rate != RATE_B) ||
                               (samples_per_frame == '0) || (tick_scale_ns == '0);
    assign status.gcd_done   = (u_reg == '0) || (v_reg == '0);
    assign status.range_fail = (nr_reg[127:64] != '0) || (dr_val > 64'h7FFF_FFFF) ||
                               (neg_reg ? (nr_reg[63:0] > 64'h8000_0000_0000_0000)
                                        : nr_reg[63]);
    assign status.out_busy   = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_FINISH || cmd.op == OP_FAIL)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                obs_reg    <= observed_tick;
                oneg_reg   <= origin_value[63];
                omag_reg   <= origin_value[63] ? (~origin_value + 64'd1) : origin_value;
                mcand_reg  <= {64'd0, frame_ordinal};
                mplier_reg <= {16'd0, samples_per_frame};
                acc_reg    <= '0;
            end
            OP_MUL_STEP:
            begin
                if (mplier_reg[0])
                    acc_reg <= acc_reg + mcand_reg;
                mcand_reg  <= {mcand_reg[126:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[31:1]};
            end
            OP_SET_B:
            begin
                mcand_reg  <= acc_reg;
                mplier_reg <= {1'b0, origin_timescale};
                acc_reg    <= '0;
            end
            OP_SET_A:
            begin
                b_reg      <= acc_reg;
                mcand_reg  <= {64'd0, omag_reg};
                mplier_reg <= {16'd0, sample_rate};
                acc_reg    <= '0;
            end
            OP_SET_D:
            begin
                a_reg      <= acc_reg;
                mcand_reg  <= {97'd0, origin_timescale};
                mplier_reg <= {16'd0, sample_rate};
                acc_reg    <= '0;
            end
            OP_CMP:
            begin
                d_reg  <= acc_reg[63:0];
                ge_reg <= b_reg >= a_reg;
            end
            OP_COMB:
            begin
                if (!oneg_reg)
                begin
                    mag_reg <= a_reg + b_reg;
                    dvd_reg <= a_reg + b_reg;
                end
                else if (ge_reg)
                begin
                    mag_reg <= b_reg - a_reg;
                    dvd_reg <= b_reg - a_reg;
                end
                else
                begin
                    mag_reg <= a_reg - b_reg;
                    dvd_reg <= a_reg - b_reg;
                end
                neg_reg <= oneg_reg && !ge_reg;
                dvs_reg <= d_reg;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                dvd_reg <= {dvd_reg[126:0], 1'b0};
                quo_reg <= {quo_reg[126:0], div_take};
                rem_reg <= div_take ? (div_shift[63:0] - dvs_reg) : div_shift[63:0];
            end
            OP_GCD_INIT:
            begin
                u_reg <= d_reg;
                v_reg <= rem_reg;
                k_reg <= '0;
            end
            OP_GCD_STEP:
            begin
                if (!u_reg[0] && !v_reg[0])
                begin
                    u_reg <= u_reg >> 1;
                    v_reg <= v_reg >> 1;
                    k_reg <= k_reg + 6'd1;
                end
                else if (!u_reg[0])
                    u_reg <= u_reg >> 1;
                else if (!v_reg[0])
                    v_reg <= v_reg >> 1;
                else if (u_reg >= v_reg)
                    u_reg <= u_reg - v_reg;
                else
                    v_reg <= v_reg - u_reg;
            end
            OP_SET_NR:
            begin
                g_reg   <= (u_reg | v_reg) << k_reg;
                dvs_reg <= (u_reg | v_reg) << k_reg;
                dvd_reg <= mag_reg;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            OP_SET_DR:
            begin
                nr_reg  <= quo_reg;
                dvd_reg <= {64'd0, d_reg};
                dvs_reg <= g_reg;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            OP_CHECK:
            begin
                mcand_reg  <= {64'd0, dr_val};
                mplier_reg <= tick_scale_ns;
                acc_reg    <= '0;
            end
            OP_SET_NS:
            begin
                den_reg    <= acc_reg[63:0];
                mcand_reg  <= {64'd0, nr_reg[63:0]};
                mplier_reg <= NS_PER_SECOND;
                acc_reg    <= '0;
            end
            OP_SET_Q:
            begin
                dvd_reg <= acc_reg;
                dvs_reg <= den_reg;
                rem_reg <= '0;
                quo_reg <= '0;
            end
            OP_ROUND:
                quo_reg <= quo_reg + {127'd0, round_up};
            OP_FINISH:
            begin
                // tick must stay inside int64 after rounding
                if (quo_reg[127:64] == '0 &&
                    (neg_reg ? (quo_reg[63:0] <= 64'h8000_0000_0000_0000) : !quo_reg[63]))
                begin
                    tick_reg  <= q_tick;
                    ok_reg    <= 1'b1;
                    match_reg <= (q_tick == obs_reg);
                end
                else
                begin
                    tick_reg  <= '0;
                    ok_reg    <= 1'b0;
                    match_reg <= 1'b0;
                end
            end
            OP_FAIL:
            begin
                tick_reg  <= '0;
                ok_reg    <= 1'b0;
                match_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign grid_tick    = tick_reg;
    assign ok           = ok_reg;
    assign tick_matches = match_reg;

endmodule

>>> rtl/audio_frame_grid_tick.sv
// top level: config registers, stream ports, sequencer and datapath
`timescale 1ns / 1ps
// work per frame: six 32-step shift-add multiplies, four 128-step restoring divisions
//   and a binary gcd; bad settings go straight to a failure result
// throughput: one frame at a time; a new input beat is taken once the previous result
//   sits in the output register, which may still be waiting on m_axis_tready
// reset (rst_n low, asynchronous): sequencer idle, output empty, registers back to
//   origin 0/1, 48000 Hz, 1024 samples per frame, 1000000 ns per tick
module audio_frame_grid_tick
    import afgt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // config write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    // input beats
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,   // frame_ordinal[63:0], observed_tick[127:64]
    // result beats
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata    // grid_tick[63:0], ok[64], tick_matches[65], zero
);

    logic [63:0] origin_value_reg;
    logic [30:0] origin_timescale_reg;
    logic [15:0] sample_rate_reg;
    logic [15:0] samples_per_frame_reg;
    logic [31:0] tick_scale_ns_reg;

    ctrl_cmd_t   cmd;
    dp_status_t  status;
    logic        in_beat;
    logic [63:0] grid_tick;
    logic        ok;
    logic        tick_matches;

    // config writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_value_reg      <= '0;
            origin_timescale_reg  <= 31'd1;
            sample_rate_reg       <= RATE_B;
            samples_per_frame_reg <= 16'd1024;
            tick_scale_ns_reg     <= 32'd1000000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_VALUE:      origin_value_reg      <= cfg_data;
                CFG_ORIGIN_TIMESCALE:  origin_timescale_reg  <= cfg_data[30:0];
                CFG_SAMPLE_RATE:       sample_rate_reg       <= cfg_data[15:0];
                CFG_SAMPLES_PER_FRAME: samples_per_frame_reg <= cfg_data[15:0];
                CFG_TICK_SCALE_NS:     tick_scale_ns_reg     <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    assign in_beat = s_axis_tvalid && s_axis_tready;

    afgt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_beat  (in_beat),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .status   (status)
    );

    afgt_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .origin_value      (origin_value_reg),
        .origin_timescale  (origin_timescale_reg),
        .sample_rate       (sample_rate_reg),
        .samples_per_frame (samples_per_frame_reg),
        .tick_scale_ns     (tick_scale_ns_reg),
        .frame_ordinal     (s_axis_tdata[63:0]),
        .observed_tick     (s_axis_tdata[127:64]),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .grid_tick         (grid_tick),
        .ok                (ok),
        .tick_matches      (tick_matches)
    );

    assign m_axis_tdata = {6'd0, tick_matches, ok, grid_tick};

endmodule
